// ----- rtl/spq_pkg.sv -----
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types, codes and defaults for the sorted priority queue.
// ----------------------------------------------------------------------------
`default_nettype none

package spq_pkg;

    // Default number of entries held
    localparam int unsigned DEPTH_DEFAULT = 128;

    // Field widths
    localparam int unsigned VALUE_W = 32;
    localparam int unsigned PRIO_W  = 16;
    localparam int unsigned FUNC_W  = 2;
    localparam int unsigned STAT_W  = 2;
    localparam int unsigned OCC_W   = 8;

    // Operation codes
    localparam logic [FUNC_W-1:0] OP_ENQUEUE = 2'd0;
    localparam logic [FUNC_W-1:0] OP_DEQUEUE = 2'd1;
    localparam logic [FUNC_W-1:0] OP_CLEAR   = 2'd2;

    // Status codes
    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

    // One stored entry
    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic signed [PRIO_W-1:0]  prio;
    } entry_t;

    // Broadcast from the controller to every cell
    typedef struct packed {
        logic   enq;        // insert new_entry this cycle
        logic   deq;        // shift every entry one place towards the head
        entry_t new_entry;
    } cell_ctrl_t;

endpackage : spq_pkg

`default_nettype wire

// ----- rtl/sorted_priority_queue_unit.sv -----
// ----------------------------------------------------------------------------
// sorted_priority_queue_unit
// Bounded priority queue kept sorted by priority number in a chain of cells.
// ----------------------------------------------------------------------------
// A request accepted at one edge (start high, busy low) has its result on
// the result ports, with done high, during the following cycle, and a new
// request may be issued in every cycle, so busy stays low. Done is high for
// that single cycle, and status and value_out hold only until the next
// accepted request; the receiver must take it then. Enqueue compares the new
// priority with all DEPTH cells at once and shifts the larger entries one
// slot back; dequeue shifts every cell one slot towards the head. Equal
// priorities leave in arrival order. Clear empties the queue. Code 3 of func
// does nothing and reports the current occupancy.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_priority_queue_unit #(
    parameter int unsigned DEPTH = spq_pkg::DEPTH_DEFAULT
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                start,
    output      logic                                busy,
    input  wire logic [spq_pkg::FUNC_W-1:0]          func,
    input  wire logic signed [spq_pkg::VALUE_W-1:0]  value_in,
    input  wire logic signed [spq_pkg::PRIO_W-1:0]   priority_in,
    output      logic                                done,
    output      logic [spq_pkg::STAT_W-1:0]          status,
    output      logic signed [spq_pkg::VALUE_W-1:0]  value_out,
    output      logic [spq_pkg::OCC_W-1:0]           occupancy,
    output      logic                                is_empty,
    output      logic                                is_full
);
    import spq_pkg::*;

    localparam int unsigned   CW      = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

    logic [CW-1:0]        count_reg;
    logic [CW-1:0]        count_next;
    logic                 done_reg;
    logic [STAT_W-1:0]    status_reg;
    logic [STAT_W-1:0]    status_next;
    logic [VALUE_W-1:0]   value_out_reg;
    logic [VALUE_W-1:0]   value_out_next;
    logic                 accept;
    logic                 full_now;
    logic                 empty_now;
    cell_ctrl_t           ctrl;

    entry_t               cell_entry [DEPTH];
    logic                 cell_ins   [DEPTH];

    assign busy      = 1'b0;
    assign accept    = start && !busy;
    assign full_now  = (count_reg >= DEPTH_C);
    assign empty_now = (count_reg == '0);

    // Decode the request into the cell broadcast
    always_comb
    begin
        ctrl.enq             = accept && (func == OP_ENQUEUE) && !full_now;
        ctrl.deq             = accept && (func == OP_DEQUEUE) && !empty_now;
        ctrl.new_entry.value = value_in;
        ctrl.new_entry.prio  = priority_in;
    end

    // Work out the count and the result
    always_comb
    begin
        count_next     = count_reg;
        status_next    = ST_OK;
        value_out_next = '0;
        case (func)
            OP_ENQUEUE:
            begin
                if (full_now)
                    status_next = ST_FULL;
                else
                    count_next = count_reg + 1'b1;
            end
            OP_DEQUEUE:
            begin
                if (empty_now)
                begin
                    status_next    = ST_EMPTY;
                    value_out_next = '1;
                end
                else
                begin
                    value_out_next = cell_entry[0].value;
                    count_next     = count_reg - 1'b1;
                end
            end
            OP_CLEAR:
            begin
                count_next = '0;
            end
            default:
            begin
                count_next = count_reg;
            end
        endcase
    end

    // Hold the count and strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= accept;
            if (accept)
                count_reg <= count_next;
        end
    end

    // Hold the result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg    <= status_next;
            value_out_reg <= value_out_next;
        end
    end

    // Build the chain of cells
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic   left_ins;
        entry_t left_entry;
        entry_t right_entry;

        if (i == 0)
        begin : g_head
            assign left_ins   = 1'b0;
            assign left_entry = cell_entry[i];
        end
        else
        begin : g_body
            assign left_ins   = cell_ins[i-1];
            assign left_entry = cell_entry[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_tail
            assign right_entry = cell_entry[i];
        end
        else
        begin : g_inner
            assign right_entry = cell_entry[i+1];
        end

        spq_cell #(
            .DEPTH (DEPTH),
            .IDX   (i)
        ) u_cell (
            .clk         (clk),
            .ctrl        (ctrl),
            .count       (count_reg),
            .left_ins    (left_ins),
            .left_entry  (left_entry),
            .right_entry (right_entry),
            .ins         (cell_ins[i]),
            .entry       (cell_entry[i])
        );
    end

    // Drive the result ports
    assign done      = done_reg;
    assign status    = status_reg;
    assign value_out = value_out_reg;
    assign occupancy = OCC_W'(count_reg);
    assign is_empty  = (count_reg == '0);
    assign is_full   = (count_reg == DEPTH_C);

    // Checks
    a_done_follows_request: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept))
        else $error("done without an accepted request");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= DEPTH_C)
        else $error("count above depth");

    a_enqueue_grows: assert property (@(posedge clk) disable iff (!rst_n)
        done && (status == ST_OK) && ($past(func) == OP_ENQUEUE)
            |-> count_reg == $past(count_reg) + 1'b1)
        else $error("accepted enqueue did not grow the queue");

    a_empty_dequeue: assert property (@(posedge clk) disable iff (!rst_n)
        done && (status == ST_EMPTY) |-> is_empty && ($past(count_reg) == '0))
        else $error("empty status with entries held");

endmodule : sorted_priority_queue_unit

`default_nettype wire

// ----- rtl/spq_cell.sv -----
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the sorted chain: holds an entry, takes the new entry, its
// left neighbour's entry or its right neighbour's entry each cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module spq_cell #(
    parameter int unsigned DEPTH = spq_pkg::DEPTH_DEFAULT,
    parameter int unsigned IDX   = 0
) (
    input  wire logic                           clk,
    input  wire spq_pkg::cell_ctrl_t            ctrl,
    input  wire logic [$clog2(DEPTH+1)-1:0]     count,
    input  wire logic                           left_ins,
    input  wire spq_pkg::entry_t                left_entry,
    input  wire spq_pkg::entry_t                right_entry,
    output      logic                           ins,
    output      spq_pkg::entry_t                entry
);
    import spq_pkg::*;

    localparam int unsigned    CW    = $clog2(DEPTH + 1);
    localparam logic [CW-1:0]  IDX_C = CW'(IDX);

    entry_t entry_reg;
    entry_t entry_next;
    logic   occupied;
    logic   greater;

    // Mark this slot as part of the insertion range: stored priority larger
    // than the new one, or the first free slot
    assign occupied = (count > IDX_C);
    assign greater  = occupied && (entry_reg.prio > ctrl.new_entry.prio);
    assign ins      = greater || (count == IDX_C);

    // Pick the next content
    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.enq)
        begin
            if (ins && left_ins)
                entry_next = left_entry;
            else if (ins)
                entry_next = ctrl.new_entry;
        end
        else if (ctrl.deq)
        begin
            entry_next = right_entry;
        end
    end

    // Hold the entry
    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule : spq_cell

`default_nettype wire
